// ===== rtl/core/q2e_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package q2e_pkg;

    localparam int QW               = 16;
    localparam int PROD_W           = 32;
    localparam int ARG_W            = 33;
    localparam int S_W              = 32;
    localparam int ROOT_W           = 31;
    localparam int RAD_W            = 62;
    localparam int DP_W             = 36;
    localparam int Z_W              = 34;
    localparam int OUT_W            = 16;
    localparam int MARGIN_W         = 15;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 15;
    localparam int QDEPTH           = 4;
    localparam int ISQ_STEPS        = 31;
    localparam int ISQ_TOP_EXP      = 2 * (ISQ_STEPS - 1);
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_MARGIN = 2'd1;
    localparam logic [MARGIN_W-1:0]  MARGIN_RESET    = 15'd33;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [ARG_W-1:0] head_y;
        logic signed [ARG_W-1:0] head_x;
        logic signed [ARG_W-1:0] bank_y;
        logic signed [ARG_W-1:0] bank_x;
        logic signed [S_W-1:0]   sin_p;
        logic                    lock;
    } q2e_item_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] q2e_atan(input int unsigned idx);
        case (idx)
            0:       return 32'd536870912;
            1:       return 32'd316933406;
            2:       return 32'd167458907;
            3:       return 32'd85004756;
            4:       return 32'd42667331;
            5:       return 32'd21354465;
            6:       return 32'd10679838;
            7:       return 32'd5340245;
            8:       return 32'd2670163;
            9:       return 32'd1335087;
            10:      return 32'd667544;
            11:      return 32'd333772;
            12:      return 32'd166886;
            13:      return 32'd83443;
            14:      return 32'd41722;
            15:      return 32'd20861;
            16:      return 32'd10430;
            17:      return 32'd5215;
            18:      return 32'd2608;
            19:      return 32'd1304;
            20:      return 32'd652;
            21:      return 32'd326;
            22:      return 32'd163;
            23:      return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/quaternion_to_euler.sv =====
// Throughput: one quaternion per cycle while full is low; the 31-stage square root and the CORDIC
// pipelines take a new item every cycle while the result slot is empty or being popped.
// Reset: rst_n clears all valid flags and the queues; direction resets to 0 and
// lock_margin to 33. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_euler
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input queue side
    input  logic                    push,
    output logic                    full,
    input  logic signed [QW-1:0]    quat_w,
    input  logic signed [QW-1:0]    quat_x,
    input  logic signed [QW-1:0]    quat_y,
    input  logic signed [QW-1:0]    quat_z,
    // result queue side
    output logic                    empty,
    input  logic                    pop,
    output logic signed [OUT_W-1:0] heading_angle,
    output logic signed [OUT_W-1:0] pitch_angle,
    output logic signed [OUT_W-1:0] bank_angle,
    output logic                    gimbal_lock,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int QCW   = $clog2(QDEPTH + 1);
    localparam int OCC_W = QCW + 1;
    localparam int IW    = $bits(q2e_item_t);

    logic                 direction_reg;
    logic [MARGIN_W-1:0]  lock_margin_reg;
    logic                 accept;
    logic                 f_valid;
    q2e_item_t            f_item;
    logic [1:0]           in_flight;
    logic [IW-1:0]        q_head_bits;
    q2e_item_t            q_head;
    logic                 q_empty;
    logic                 q_pop;
    logic [QCW-1:0]       q_count;
    logic [OCC_W-1:0]     occupancy;

    // Configuration: always ready; the user must issue writes only while the block is idle (not enforced
    // by the block), as the front end reads the registers live. Unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= 1'b0;
            lock_margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIRECTION:   direction_reg   <= cfg_data[0];
                REG_LOCK_MARGIN: lock_margin_reg <= cfg_data[MARGIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Credit check: the front end never stalls, so hold off new transfers once
    // items in flight plus those queued would fill the hand-off queue.
    assign occupancy = OCC_W'(q_count) + OCC_W'(in_flight);
    assign full      = occupancy >= OCC_W'(QDEPTH);
    assign accept    = push && !full;

    // Front: form the nine products, then the pitch sine, the lock decision
    // and the atan2 arguments for heading and bank.
    q2e_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .direction   (direction_reg),
        .lock_margin (lock_margin_reg),
        .item_valid  (f_valid),
        .item        (f_item),
        .in_flight   (in_flight)
    );

    // Short hand-off queue so the back end can stall while the front end keeps running.
    q2e_queue #(
        .W     (IW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .din   (f_item),
        .pop   (q_pop),
        .dout  (q_head_bits),
        .empty (q_empty),
        .count (q_count)
    );

    assign q_head = q_head_bits;

    // Back: square root for cos(pitch), three CORDIC vectoring pipelines,
    // rounding, and the output register that holds a result until popped.
    q2e_back #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .heading_angle (heading_angle),
        .pitch_angle   (pitch_angle),
        .bank_angle    (bank_angle),
        .gimbal_lock   (gimbal_lock)
    );

    // The hand-off queue is never written while full.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid |-> (q_count < QCW'(QDEPTH)))
        else $error("hand-off queue written while full");

    // Credits never exceed the queue depth.
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= OCC_W'(QDEPTH))
        else $error("front-end credits exceed queue depth");

    // Under gimbal lock the bank angle is forced to zero.
    a_lock_bank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && gimbal_lock) |-> (bank_angle == '0))
        else $error("bank angle nonzero under gimbal lock");

endmodule

`default_nettype wire

// ===== rtl/core/q2e_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_front
    import q2e_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic signed [QW-1:0]    quat_w,
    input  logic signed [QW-1:0]    quat_x,
    input  logic signed [QW-1:0]    quat_y,
    input  logic signed [QW-1:0]    quat_z,
    input  logic                    direction,
    input  logic [MARGIN_W-1:0]     lock_margin,
    output logic                    item_valid,
    output q2e_item_t               item,
    output logic [1:0]              in_flight
);

    localparam int T_W = PROD_W + 3;
    localparam int A_W = ARG_W + 1;
    localparam logic signed [T_W-1:0] ONE_T  = 1 <<< 30;
    localparam logic signed [A_W-1:0] HALF_A = 1 <<< 29;

    logic                     f1_v_reg;
    logic                     f2_v_reg;
    logic signed [PROD_W-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg;
    q2e_item_t                item_reg;
    q2e_item_t                item_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= accept;
            f2_v_reg <= f1_v_reg;
        end
    end

    // products, exact in Q2.30
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wx_reg <= PROD_W'(quat_w) * PROD_W'(quat_x);
            wy_reg <= PROD_W'(quat_w) * PROD_W'(quat_y);
            wz_reg <= PROD_W'(quat_w) * PROD_W'(quat_z);
            xx_reg <= PROD_W'(quat_x) * PROD_W'(quat_x);
            yy_reg <= PROD_W'(quat_y) * PROD_W'(quat_y);
            zz_reg <= PROD_W'(quat_z) * PROD_W'(quat_z);
            xy_reg <= PROD_W'(quat_x) * PROD_W'(quat_y);
            xz_reg <= PROD_W'(quat_x) * PROD_W'(quat_z);
            yz_reg <= PROD_W'(quat_y) * PROD_W'(quat_z);
        end
    end

    always_comb
    begin
        logic signed [T_W-1:0] wx_t;
        logic signed [T_W-1:0] sum_s;
        logic signed [T_W-1:0] s_raw;
        logic signed [T_W-1:0] s_sat;
        logic signed [S_W-1:0] s_v;
        logic [S_W-1:0]        mag;
        logic [S_W-1:0]        thr;
        logic                  lock;
        logic signed [A_W-1:0] wy_t;
        logic signed [A_W-1:0] wz_t;
        logic signed [A_W-1:0] hy;
        logic signed [A_W-1:0] hx;
        logic signed [A_W-1:0] by;
        logic signed [A_W-1:0] bx;

        wx_t  = direction ? -T_W'(wx_reg) : T_W'(wx_reg);
        sum_s = T_W'(yz_reg) + wx_t;
        s_raw = -(sum_s <<< 1);
        if (s_raw > ONE_T)
            s_sat = ONE_T;
        else if (s_raw < -ONE_T)
            s_sat = -ONE_T;
        else
            s_sat = s_raw;
        s_v  = S_W'(s_sat);
        mag  = s_v[S_W-1] ? S_W'(-s_v) : S_W'(s_v);
        thr  = S_W'(1 << 30) - (S_W'(lock_margin) << 15);
        lock = mag > thr;

        wy_t = direction ? A_W'(wy_reg) : -A_W'(wy_reg);
        wz_t = direction ? A_W'(wz_reg) : -A_W'(wz_reg);
        hy   = (lock ? -A_W'(xz_reg) : A_W'(xz_reg)) + wy_t;
        hx   = HALF_A - A_W'(lock ? zz_reg : xx_reg) - A_W'(yy_reg);
        by   = A_W'(xy_reg) + wz_t;
        bx   = HALF_A - A_W'(xx_reg) - A_W'(zz_reg);

        item_next.head_y = ARG_W'(hy);
        item_next.head_x = ARG_W'(hx);
        item_next.bank_y = ARG_W'(by);
        item_next.bank_x = ARG_W'(bx);
        item_next.sin_p  = s_v;
        item_next.lock   = lock;
    end

    always_ff @(posedge clk)
    begin
        if (f1_v_reg)
            item_reg <= item_next;
    end

    assign item_valid = f2_v_reg;
    assign item       = item_reg;
    assign in_flight  = {1'b0, f1_v_reg} + {1'b0, f2_v_reg};

endmodule

`default_nettype wire

// ===== rtl/core/q2e_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_queue
    import q2e_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QDEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [W-1:0]               din,
    input  logic                       pop,
    output logic [W-1:0]               dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/q2e_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_isqrt
    import q2e_pkg::*;
#(
    parameter int PW = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [PW-1:0]     in_pay,
    input  logic [RAD_W-1:0]  in_rad,
    output logic              out_valid,
    output logic [PW-1:0]     out_pay,
    output logic [ROOT_W-1:0] root
);

    logic              vld_reg [ISQ_STEPS];
    logic [PW-1:0]     pay_reg [ISQ_STEPS];
    logic [RAD_W-1:0]  rem_reg [ISQ_STEPS];
    logic [RAD_W-1:0]  res_reg [ISQ_STEPS];

    // one result bit per stage
    function automatic logic [2*RAD_W-1:0] isq_step(input logic [RAD_W-1:0] rem,
                                                    input logic [RAD_W-1:0] res,
                                                    input int k);
        logic [RAD_W-1:0] bitv;
        logic [RAD_W-1:0] trial;
        bitv  = RAD_W'(1) << (ISQ_TOP_EXP - 2 * k);
        trial = res + bitv;
        if (rem >= trial)
            return {rem - trial, (res >> 1) + bitv};
        return {rem, res >> 1};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ISQ_STEPS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < ISQ_STEPS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0]                <= in_pay;
            {rem_reg[0], res_reg[0]}  <= isq_step(in_rad, '0, 0);
            for (int k = 1; k < ISQ_STEPS; k++)
            begin
                pay_reg[k]               <= pay_reg[k-1];
                {rem_reg[k], res_reg[k]} <= isq_step(rem_reg[k-1], res_reg[k-1], k);
            end
        end
    end

    assign out_valid = vld_reg[ISQ_STEPS-1];
    assign out_pay   = pay_reg[ISQ_STEPS-1];
    assign root      = res_reg[ISQ_STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/q2e_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_cordic
    import q2e_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ARG_W-1:0] arg_y,
    input  logic signed [ARG_W-1:0] arg_x,
    output logic signed [Z_W-1:0]   angle
);

    localparam logic signed [Z_W-1:0] QUARTER = 1 <<< 30;

    logic signed [DP_W-1:0] x_reg    [STEPS+1];
    logic signed [DP_W-1:0] y_reg    [STEPS+1];
    logic signed [Z_W-1:0]  z_reg    [STEPS+1];
    logic                   zero_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // fold the left half plane by a quarter turn
            zero_reg[0] <= (arg_x == '0) && (arg_y == '0);
            if (arg_x < 0)
            begin
                if (arg_y >= 0)
                begin
                    x_reg[0] <= DP_W'(arg_y);
                    y_reg[0] <= -DP_W'(arg_x);
                    z_reg[0] <= QUARTER;
                end
                else
                begin
                    x_reg[0] <= -DP_W'(arg_y);
                    y_reg[0] <= DP_W'(arg_x);
                    z_reg[0] <= -QUARTER;
                end
            end
            else
            begin
                x_reg[0] <= DP_W'(arg_x);
                y_reg[0] <= DP_W'(arg_y);
                z_reg[0] <= '0;
            end

            for (int i = 0; i < STEPS; i++)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][DP_W-1] && (y_reg[i] != '0))
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + Z_W'(q2e_atan(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - Z_W'(q2e_atan(i));
                end
            end
        end
    end

    assign angle = zero_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule

`default_nettype wire

// ===== rtl/core/q2e_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_back
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  q2e_item_t               q_head,
    output logic                    q_pop,
    input  logic                    pop,
    output logic                    empty,
    output logic signed [OUT_W-1:0] heading_angle,
    output logic signed [OUT_W-1:0] pitch_angle,
    output logic signed [OUT_W-1:0] bank_angle,
    output logic                    gimbal_lock
);

    localparam int IW       = $bits(q2e_item_t);
    localparam int RND_SH   = 32 - ANGLE_BITS;
    localparam int RND_HALF = (RND_SH == 0) ? 0 : (1 << (RND_SH - 1));
    localparam int GP_SH    = ANGLE_BITS - 2;
    localparam int GW       = S_W + 31;

    logic                   en;
    logic                   b0_v_reg;
    logic                   b1_v_reg;
    q2e_item_t              b0_item_reg;
    q2e_item_t              b1_item_reg;
    logic [RAD_W-1:0]       b0_sq_reg;
    logic [RAD_W-1:0]       b1_rad_reg;
    logic [ROOT_W-1:0]      s_abs;
    logic                   iv;
    logic [IW-1:0]          ipay_bits;
    q2e_item_t              ipay;
    logic [ROOT_W-1:0]      root;
    logic signed [Z_W-1:0]  z_head, z_pitch, z_bank;
    logic                   dl_v_reg    [CORDIC_STEPS+1];
    logic                   dl_lock_reg [CORDIC_STEPS+1];
    logic signed [S_W-1:0]  dl_s_reg    [CORDIC_STEPS+1];
    logic                   out_v_reg;
    logic [OUT_W-1:0]       heading_reg, pitch_reg, bank_reg;
    logic                   lock_reg;

    function automatic logic [OUT_W-1:0] to_angle(input logic signed [Z_W-1:0] z);
        logic [Z_W-1:0] mag;
        logic [Z_W-1:0] r;
        logic [Z_W-1:0] v;
        mag = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
        r   = (mag + Z_W'(RND_HALF)) >> RND_SH;
        v   = z[Z_W-1] ? -r : r;
        return v[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] lock_pitch(input logic signed [S_W-1:0] s);
        logic [S_W-1:0] mag;
        logic [GW-1:0]  r;
        logic [GW-1:0]  v;
        mag = s[S_W-1] ? S_W'(-s) : S_W'(s);
        r   = ((GW'(mag) << GP_SH) + (GW'(1) << 29)) >> 30;
        v   = s[S_W-1] ? -r : r;
        return v[OUT_W-1:0];
    endfunction

    // advance the whole back end whenever the result slot frees up
    assign en    = !out_v_reg || pop;
    assign q_pop = en && !q_empty;
    assign s_abs = q_head.sin_p[S_W-1] ? ROOT_W'(-q_head.sin_p) : ROOT_W'(q_head.sin_p);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_v_reg <= 1'b0;
            b1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_v_reg <= !q_empty;
            b1_v_reg <= b0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_item_reg <= q_head;
            b0_sq_reg   <= RAD_W'(s_abs) * RAD_W'(s_abs);
            b1_item_reg <= b0_item_reg;
            b1_rad_reg  <= (RAD_W'(1) << ISQ_TOP_EXP) - b0_sq_reg;
        end
    end

    q2e_isqrt #(
        .PW (IW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b1_v_reg),
        .in_pay    (b1_item_reg),
        .in_rad    (b1_rad_reg),
        .out_valid (iv),
        .out_pay   (ipay_bits),
        .root      (root)
    );

    assign ipay = ipay_bits;

    q2e_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_head (
        .clk   (clk),
        .en    (en),
        .arg_y (ipay.head_y),
        .arg_x (ipay.head_x),
        .angle (z_head)
    );

    q2e_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_pitch (
        .clk   (clk),
        .en    (en),
        .arg_y (ARG_W'(ipay.sin_p)),
        .arg_x (ARG_W'({1'b0, root})),
        .angle (z_pitch)
    );

    q2e_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_bank (
        .clk   (clk),
        .en    (en),
        .arg_y (ipay.bank_y),
        .arg_x (ipay.bank_x),
        .angle (z_bank)
    );

    // carry valid, lock and sine alongside the CORDIC stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
                dl_v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            dl_v_reg[0] <= iv;
            for (int k = 1; k <= CORDIC_STEPS; k++)
                dl_v_reg[k] <= dl_v_reg[k-1];
            out_v_reg <= dl_v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_lock_reg[0] <= ipay.lock;
            dl_s_reg[0]    <= ipay.sin_p;
            for (int k = 1; k <= CORDIC_STEPS; k++)
            begin
                dl_lock_reg[k] <= dl_lock_reg[k-1];
                dl_s_reg[k]    <= dl_s_reg[k-1];
            end
            heading_reg <= to_angle(z_head);
            pitch_reg   <= dl_lock_reg[CORDIC_STEPS] ? lock_pitch(dl_s_reg[CORDIC_STEPS])
                                                     : to_angle(z_pitch);
            bank_reg    <= dl_lock_reg[CORDIC_STEPS] ? '0 : to_angle(z_bank);
            lock_reg    <= dl_lock_reg[CORDIC_STEPS];
        end
    end

    assign empty         = !out_v_reg;
    assign heading_angle = heading_reg;
    assign pitch_angle   = pitch_reg;
    assign bank_angle    = bank_reg;
    assign gimbal_lock   = lock_reg;

endmodule

`default_nettype wire
